### rtl/core/ece_pkg.sv
// easing curve evaluator: shared types, constants and rom builders
// no dependencies; used by easing_curve_evaluator_core
`timescale 1ns / 1ps

package ece_pkg;

  typedef enum logic [2:0] {
    CMD_LINEAR      = 3'd0,
    CMD_IN_QUAD     = 3'd1,
    CMD_OUT_QUAD    = 3'd2,
    CMD_INOUT_QUAD  = 3'd3,
    CMD_OUT_BACK    = 3'd4,
    CMD_OUT_ELASTIC = 3'd5,
    CMD_OUT_BOUNCE  = 3'd6,
    CMD_LINEAR_ALT  = 3'd7
  } cmd_e;

  localparam int EXP_BITS  = 10;
  localparam int EXP_DEPTH = 1 << EXP_BITS;
  localparam int ROM_W     = 31;

  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
  localparam longint unsigned Q30_LN2     = 64'd744261118;
  localparam longint unsigned Q30_BACK_C1 = 64'd1827057613;
  localparam longint unsigned Q30_BACK_C3 = 64'd2900799437;
  localparam longint          Q30_ONE     = 64'sd1073741824;

  // taylor series for sin(x), x in q30, evaluated at elaboration
  function automatic logic [ROM_W-1:0] sine_series(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 12; k++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) sum = 0;
    if (sum > Q30_ONE) sum = Q30_ONE;
    return ROM_W'(sum);
  endfunction

  // 2^(-i/2^EXP_BITS) in q30 through the series of exp(-i*ln2/2^EXP_BITS)
  function automatic logic [ROM_W-1:0] exp2_entry(int i);
    longint unsigned y;
    longint unsigned term;
    longint          sum;
    y = (64'(i) * Q30_LN2) >> EXP_BITS;
    term = 64'd1 << 30;
    sum = Q30_ONE;
    for (int k = 1; k <= 16; k++) begin
      term = ((term * y) >> 30) / 64'(k);
      if ((k & 1) != 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) sum = 0;
    if (sum > Q30_ONE) sum = Q30_ONE;
    return ROM_W'(sum);
  endfunction

endpackage

### rtl/core/easing_curve_evaluator_core.sv
// easing curve evaluator: eight-stage pipeline over all curves
// depends on ece_pkg (curve codes, rom builders, q30 constants)
`timescale 1ns / 1ps

// Usage
//   Input channel: a transaction is taken at each rising edge where start_i is
//   high and busy_o is low. busy_o is always low, so one transaction can be
//   given every clock cycle. cmd_i picks the curve, progress_i is the signed
//   fixed-point progress, clamped to 0..1 inside.
//   Output channel: done_o is high for exactly one cycle with eased_value_o
//   valid in that cycle; results come out in input order.
//   Each input passes through the stage registers in order, ending in the output register that drives eased_value_o.
//   Throughput: one result per cycle, sustained.
//   The depth follows the back-out chain of dependent multiplies (three
//   products, each rounded in a stage of its own) and, for elastic-out, the
//   exp2 rom read, the phase reciprocal multiply and the sine rom read.
//   Reset clears the valid line only; no transaction is in flight afterwards.
//   The roms are constant, so there is no fill or clearing pass after reset.
//   The receiver cannot stall, so the pipeline never holds.
module easing_curve_evaluator_core #(
  parameter int FRAC_BITS        = 16,
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         cmd_i,
  input  logic signed [17:0] progress_i,
  output logic               done_o,
  output logic signed [17:0] eased_value_o
);

  localparam int F    = FRAC_BITS;
  localparam int D    = SINE_TABLE_DEPTH;
  localparam int TW   = F + 1;
  localparam int OW   = F + 2;
  localparam int CW   = (F + 2 > 18) ? F + 2 : 18;
  localparam int AW   = (F + 4 > 18) ? F + 4 : 18;
  localparam int DW   = $clog2(D + 1);
  localparam int YW   = DW + 6;
  localparam int SW   = YW + 2;
  localparam int RW   = YW + SW;
  localparam int QW   = 2 * OW;
  localparam int BQW  = 2 * F + 6;
  localparam int T11W = F + 4;
  localparam int DSW  = F + 6;
  localparam int DMW  = F + 3;
  localparam int EW   = F + 4;
  localparam int KW   = F + 11;
  localparam int NW   = F + 6;
  localparam int XW   = F + 6 + DW;
  localparam int C1W  = F + 1;
  localparam int C3W  = F + 2;
  localparam int KIW  = ece_pkg::EXP_BITS + 1;
  localparam int RMW  = ece_pkg::ROM_W;
  localparam int PRW  = 2 * RMW;

  localparam logic [TW-1:0] ONE_T  = {1'b1, {F{1'b0}}};
  localparam logic [TW-1:0] HALF_T = {2'b01, {(F - 1){1'b0}}};
  localparam logic [OW-1:0] TWO_T  = {2'b10, {F{1'b0}}};
  localparam logic signed [CW-1:0] ONE_C = CW'(ONE_T);

  localparam logic [T11W-1:0] B_LIM1 = T11W'(64'd4 << F);
  localparam logic [T11W-1:0] B_LIM2 = T11W'(64'd8 << F);
  localparam logic [T11W-1:0] B_LIM3 = T11W'(64'd10 << F);
  localparam logic signed [DSW-1:0] B_SIX  = DSW'(64'sd6 <<< F);
  localparam logic signed [DSW-1:0] B_NINE = DSW'(64'sd9 <<< F);
  localparam logic signed [DSW-1:0] B_TW1  = DSW'(64'sd21 <<< F);
  localparam logic [TW-1:0] B_OFF1 = TW'(3 * (64'd1 << (F - 2)));
  localparam logic [TW-1:0] B_OFF2 = TW'(15 * (64'd1 << (F - 4)));
  localparam logic [TW-1:0] B_OFF3 = TW'(63 * (64'd1 << (F - 6)));

  localparam logic [KW-1:0] K_HALF   = KW'(64'd1 << (F - 1));
  localparam logic [NW-1:0] NINE_ONE = NW'(64'd9 << F);
  localparam logic [XW-1:0] X_BIAS   = XW'(64'd3 << (F - 1));
  localparam logic [SW-1:0] RECIP3   = SW'((64'd1 << SW) / 3);

  localparam longint unsigned C1_L = (ece_pkg::Q30_BACK_C1 + (64'd1 << (29 - F))) >> (30 - F);
  localparam longint unsigned C3_L = (ece_pkg::Q30_BACK_C3 + (64'd1 << (29 - F))) >> (30 - F);
  localparam logic [C1W-1:0] C1 = C1W'(C1_L);
  localparam logic [C3W-1:0] C3 = C3W'(C3_L);

  // constant roms
  logic [RMW-1:0] sine_rom [D + 1];
  logic [RMW-1:0] exp_rom  [ece_pkg::EXP_DEPTH + 1];

  for (genvar gi = 0; gi <= D; gi++) begin : g_sine
    localparam longint unsigned SX = (64'(gi) * ece_pkg::Q30_HALF_PI) / D;
    localparam logic [RMW-1:0] SIN_V = ece_pkg::sine_series(SX);
    assign sine_rom[gi] = SIN_V;
  end

  for (genvar gi = 0; gi <= ece_pkg::EXP_DEPTH; gi++) begin : g_exp
    localparam logic [RMW-1:0] EXP_V = ece_pkg::exp2_entry(gi);
    assign exp_rom[gi] = EXP_V;
  end

  assign busy_o = 1'b0;

  // valid line, one bit per stage
  logic [7:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[6:0], start_i & ~busy_o};
    end
  end

  // ---------------- stage 1: clamp
  logic signed [CW-1:0] prog_ext;
  logic [TW-1:0]        t_d;
  assign prog_ext = CW'(progress_i);

  always_comb begin
    priority if (prog_ext < 0) begin
      t_d = '0;
    end else if (prog_ext > ONE_C) begin
      t_d = ONE_T;
    end else begin
      t_d = prog_ext[TW-1:0];
    end
  end

  ece_pkg::cmd_e cmd_s1_q;
  logic [TW-1:0] t_s1_q;
  always_ff @(posedge clk_i) begin
    cmd_s1_q <= ece_pkg::cmd_e'(cmd_i);
    t_s1_q   <= t_d;
  end

  // ---------------- stage 2: first products, bounce segment, elastic indexes
  logic [TW-1:0]          r_d;
  logic                   lo_half;
  logic [OW-1:0]          qa, qb;
  logic [QW-1:0]          qprod_d;
  logic                   qdbl_d, qinv_d;
  logic [2*TW-1:0]        bsq_d;
  logic [T11W-1:0]        t11;
  logic signed [DSW-1:0]  t11s, bd;
  logic [DMW-1:0]         bmag;
  logic [BQW-1:0]         dsq_d;
  logic [1:0]             seg_d;
  logic [EW-1:0]          e10;
  logic [KW-1:0]          kx;
  logic [NW-1:0]          num;
  logic [XW-1:0]          xnum;

  always_comb begin
    r_d     = ONE_T - t_s1_q;
    lo_half = (t_s1_q < HALF_T);
    qdbl_d  = 1'b0;
    qinv_d  = 1'b0;
    unique case (cmd_s1_q)
      ece_pkg::CMD_OUT_QUAD: begin
        qa = OW'(t_s1_q);
        qb = TWO_T - OW'(t_s1_q);
      end
      ece_pkg::CMD_INOUT_QUAD: begin
        qa     = lo_half ? OW'(t_s1_q) : OW'(r_d);
        qb     = qa;
        qdbl_d = 1'b1;
        qinv_d = ~lo_half;
      end
      default: begin
        qa = OW'(t_s1_q);
        qb = OW'(t_s1_q);
      end
    endcase
    qprod_d = QW'(qa) * QW'(qb);
    bsq_d   = (2 * TW)'(r_d) * (2 * TW)'(r_d);

    // bounce: segment limits 4/11, 8/11, 10/11 compared on 11t
    t11  = T11W'(t_s1_q) * T11W'(11);
    t11s = DSW'(t11);
    priority if (t11 < B_LIM1) begin
      seg_d = 2'd0;
      bd    = t11s;
    end else if (t11 < B_LIM2) begin
      seg_d = 2'd1;
      bd    = t11s - B_SIX;
    end else if (t11 < B_LIM3) begin
      seg_d = 2'd2;
      bd    = t11s - B_NINE;
    end else begin
      seg_d = 2'd3;
      bd    = (t11s <<< 1) - B_TW1;
    end
    bmag  = (bd < 0) ? DMW'(-bd) : DMW'(bd);
    dsq_d = BQW'(bmag) * BQW'(bmag);

    // elastic: 10t split into shift count and rounded table index
    e10  = EW'(t_s1_q) * EW'(10);
    kx   = {1'b0, e10[F-1:0], 10'b0} + K_HALF;
    num  = NW'(t_s1_q) * NW'(40) + NINE_ONE;
    xnum = XW'(num) * XW'(D) + X_BIAS;
  end

  ece_pkg::cmd_e    cmd_s2_q;
  logic [TW-1:0]    t_s2_q, br_s2_q;
  logic [QW-1:0]    qprod_s2_q;
  logic             qdbl_s2_q, qinv_s2_q;
  logic [2*TW-1:0]  bsq_s2_q;
  logic [1:0]       seg_s2_q;
  logic [BQW-1:0]   dsq_s2_q;
  logic [3:0]       en_s2_q;
  logic [KIW-1:0]   ek_s2_q;
  logic [YW-1:0]    ey_s2_q;
  logic             ez_s2_q, eo_s2_q;

  always_ff @(posedge clk_i) begin
    cmd_s2_q   <= cmd_s1_q;
    t_s2_q     <= t_s1_q;
    br_s2_q    <= r_d;
    qprod_s2_q <= qprod_d;
    qdbl_s2_q  <= qdbl_d;
    qinv_s2_q  <= qinv_d;
    bsq_s2_q   <= bsq_d;
    seg_s2_q   <= seg_d;
    dsq_s2_q   <= dsq_d;
    en_s2_q    <= e10[F+3:F];
    ek_s2_q    <= kx[KW-1:F];
    ey_s2_q    <= xnum[XW-1:F];
    ez_s2_q    <= (t_s1_q == '0);
    eo_s2_q    <= (t_s1_q == ONE_T);
  end

  // ---------------- stage 3: quad and bounce results, back r^2, exp rom read, phase reciprocal product
  logic [QW-1:0]        qsum;
  logic [TW-1:0]        qr, qy;
  logic [BQW-1:0]       bsum;
  logic [TW-1:0]        bq, by;
  logic [2*TW-1:0]      r2sum;
  logic signed [AW-1:0] acc_s3_d;

  always_comb begin
    qsum = qprod_s2_q + (qdbl_s2_q ? (QW'(1) << (F - 2)) : (QW'(1) << (F - 1)));
    qr   = qdbl_s2_q ? TW'(qsum >> (F - 1)) : TW'(qsum >> F);
    qy   = qinv_s2_q ? ONE_T - qr : qr;

    bsum = dsq_s2_q + ((seg_s2_q == 2'd3) ? (BQW'(1) << (F + 5)) : (BQW'(1) << (F + 3)));
    unique case (seg_s2_q)
      2'd0: begin
        bq = TW'(bsum >> (F + 4));
        by = bq;
      end
      2'd1: begin
        bq = TW'(bsum >> (F + 4));
        by = bq + B_OFF1;
      end
      2'd2: begin
        bq = TW'(bsum >> (F + 4));
        by = bq + B_OFF2;
      end
      default: begin
        bq = TW'(bsum >> (F + 6));
        by = bq + B_OFF3;
      end
    endcase

    unique case (cmd_s2_q)
      ece_pkg::CMD_IN_QUAD, ece_pkg::CMD_OUT_QUAD, ece_pkg::CMD_INOUT_QUAD: acc_s3_d = AW'(qy);
      ece_pkg::CMD_OUT_BOUNCE: acc_s3_d = AW'(by);
      default: acc_s3_d = AW'(t_s2_q);
    endcase

    r2sum = bsq_s2_q + (2 * TW)'(HALF_T);
  end

  ece_pkg::cmd_e        cmd_s3_q;
  logic signed [AW-1:0] acc_s3_q;
  logic [TW-1:0]        br_s3_q, br2_s3_q;
  logic [RMW-1:0]       exp_s3_q;
  logic [3:0]           en_s3_q;
  logic [YW-1:0]        ey_s3_q;
  logic [RW-1:0]        eq0p_s3_q;
  logic                 ez_s3_q, eo_s3_q;

  always_ff @(posedge clk_i) begin
    cmd_s3_q  <= cmd_s2_q;
    acc_s3_q  <= acc_s3_d;
    br_s3_q   <= br_s2_q;
    br2_s3_q  <= TW'(r2sum >> F);
    exp_s3_q  <= exp_rom[ek_s2_q];
    en_s3_q   <= en_s2_q;
    ey_s3_q   <= ey_s2_q;
    eq0p_s3_q <= RW'(ey_s2_q) * RW'(RECIP3);
    ez_s3_q   <= ez_s2_q;
    eo_s3_q   <= eo_s2_q;
  end

  // ---------------- stage 4: back products, phase quotient, exp shift
  logic [2*TW-1:0]    br3p_d;
  logic [C1W+TW-1:0]  bc1p_d;
  logic [YW-1:0]      q0, q0x3, rem, p_d;
  logic [RMW:0]       erb, esum;
  logic [RMW-1:0]     expv_d;

  always_comb begin
    br3p_d = (2 * TW)'(br2_s3_q) * (2 * TW)'(br_s3_q);
    bc1p_d = (C1W + TW)'(C1) * (C1W + TW)'(br2_s3_q);

    // divide by 3 through the reciprocal, off by at most one
    q0   = eq0p_s3_q[RW-1:SW];
    q0x3 = {q0[YW-2:0], 1'b0} + q0;
    rem  = ey_s3_q - q0x3;
    p_d  = (rem >= YW'(3)) ? q0 + YW'(1) : q0;

    erb    = (en_s3_q == 4'd0) ? '0 : ((RMW + 1)'(1) << (en_s3_q - 4'd1));
    esum   = {1'b0, exp_s3_q} + erb;
    expv_d = RMW'(esum >> en_s3_q);
  end

  ece_pkg::cmd_e        cmd_s4_q;
  logic signed [AW-1:0] acc_s4_q;
  logic [2*TW-1:0]      br3p_s4_q;
  logic [C1W+TW-1:0]    bc1p_s4_q;
  logic [YW-1:0]        p_s4_q;
  logic [RMW-1:0]       expv_s4_q;
  logic                 ez_s4_q, eo_s4_q;

  always_ff @(posedge clk_i) begin
    cmd_s4_q  <= cmd_s3_q;
    acc_s4_q  <= acc_s3_q;
    br3p_s4_q <= br3p_d;
    bc1p_s4_q <= bc1p_d;
    p_s4_q    <= p_d;
    expv_s4_q <= expv_d;
    ez_s4_q   <= ez_s3_q;
    eo_s4_q   <= eo_s3_q;
  end

  // ---------------- stage 5: back rounding, sine quadrant and address
  logic [2*TW-1:0]   r3sum;
  logic [C1W+TW-1:0] c1sum;
  logic [4:0]        quad_n;
  logic [YW-1:0]     qbase;
  logic [DW-1:0]     sidx, saddr_d;

  always_comb begin
    r3sum = br3p_s4_q + (2 * TW)'(HALF_T);
    c1sum = bc1p_s4_q + (C1W + TW)'(HALF_T);

    // p stays below 17 quarter waves: find the quarter by parallel compares
    quad_n = '0;
    qbase  = '0;
    for (int k = 1; k <= 16; k++) begin
      if (p_s4_q >= YW'(k * D)) begin
        quad_n = 5'(k);
        qbase  = YW'(k * D);
      end
    end
    sidx    = DW'(p_s4_q - qbase);
    saddr_d = quad_n[0] ? DW'(D) - sidx : sidx;
  end

  ece_pkg::cmd_e        cmd_s5_q;
  logic signed [AW-1:0] acc_s5_q;
  logic [TW-1:0]        br3_s5_q;
  logic [C1W-1:0]       bc1t_s5_q;
  logic [DW-1:0]        saddr_s5_q;
  logic                 sneg_s5_q;
  logic [RMW-1:0]       expv_s5_q;
  logic                 ez_s5_q, eo_s5_q;

  always_ff @(posedge clk_i) begin
    cmd_s5_q   <= cmd_s4_q;
    acc_s5_q   <= acc_s4_q;
    br3_s5_q   <= TW'(r3sum >> F);
    bc1t_s5_q  <= C1W'(c1sum >> F);
    saddr_s5_q <= saddr_d;
    sneg_s5_q  <= quad_n[1];
    expv_s5_q  <= expv_s4_q;
    ez_s5_q    <= ez_s4_q;
    eo_s5_q    <= eo_s4_q;
  end

  // ---------------- stage 6: back c3 product, sine rom read
  ece_pkg::cmd_e        cmd_s6_q;
  logic signed [AW-1:0] acc_s6_q;
  logic [C3W+TW-1:0]    bc3p_s6_q;
  logic [C1W-1:0]       bc1t_s6_q;
  logic [RMW-1:0]       sin_s6_q;
  logic                 sneg_s6_q;
  logic [RMW-1:0]       expv_s6_q;
  logic                 ez_s6_q, eo_s6_q;

  always_ff @(posedge clk_i) begin
    cmd_s6_q  <= cmd_s5_q;
    acc_s6_q  <= acc_s5_q;
    bc3p_s6_q <= (C3W + TW)'(C3) * (C3W + TW)'(br3_s5_q);
    bc1t_s6_q <= bc1t_s5_q;
    sin_s6_q  <= sine_rom[saddr_s5_q];
    sneg_s6_q <= sneg_s5_q;
    expv_s6_q <= expv_s5_q;
    ez_s6_q   <= ez_s5_q;
    eo_s6_q   <= eo_s5_q;
  end

  // ---------------- stage 7: back sum, elastic product
  logic [C3W+TW-1:0]    c3sum;
  logic signed [AW-1:0] back_y, acc_s7_d;

  always_comb begin
    c3sum  = bc3p_s6_q + (C3W + TW)'(HALF_T);
    back_y = AW'(ONE_T) + AW'(bc1t_s6_q) - AW'(c3sum >> F);
    acc_s7_d = (cmd_s6_q == ece_pkg::CMD_OUT_BACK) ? back_y : acc_s6_q;
  end

  ece_pkg::cmd_e        cmd_s7_q;
  logic signed [AW-1:0] acc_s7_q;
  logic [PRW-1:0]       eprod_s7_q;
  logic                 sneg_s7_q;
  logic                 ez_s7_q, eo_s7_q;

  always_ff @(posedge clk_i) begin
    cmd_s7_q   <= cmd_s6_q;
    acc_s7_q   <= acc_s7_d;
    eprod_s7_q <= PRW'(expv_s6_q) * PRW'(sin_s6_q);
    sneg_s7_q  <= sneg_s6_q;
    ez_s7_q    <= ez_s6_q;
    eo_s7_q    <= eo_s6_q;
  end

  // ---------------- stage 8: elastic rounding and end points, output register
  logic [PRW-1:0]       epsum;
  logic [TW-1:0]        emag;
  logic signed [AW-1:0] elastic_y, final_y;
  logic signed [17:0]   eased_value_d;

  always_comb begin
    epsum = eprod_s7_q + (PRW'(1) << (59 - F));
    emag  = TW'(epsum >> (60 - F));
    priority if (ez_s7_q) begin
      elastic_y = '0;
    end else if (eo_s7_q) begin
      elastic_y = AW'(ONE_T);
    end else if (sneg_s7_q) begin
      elastic_y = AW'(ONE_T) - AW'(emag);
    end else begin
      elastic_y = AW'(ONE_T) + AW'(emag);
    end
    final_y = (cmd_s7_q == ece_pkg::CMD_OUT_ELASTIC) ? elastic_y : acc_s7_q;
    eased_value_d = final_y[17:0];
  end

  logic signed [17:0] eased_value_q;
  always_ff @(posedge clk_i) begin
    eased_value_q <= eased_value_d;
  end

  assign done_o        = vld_q[7];
  assign eased_value_o = eased_value_q;

endmodule
